// ===== rtl/core/ibfd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibfd_pkg
// Shared constants, codes and interface structs of the iBus frame decoder.
// ----------------------------------------------------------------------------
package ibfd_pkg;

    // Number of channels carried in one frame (5 to 14).
    localparam int CHANNELS = 14;
    localparam int CH_AW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    localparam int POS_W    = 5;
    localparam int IDX_W    = 4;
    localparam int KIND_W   = 3;
    localparam int OP_W     = 2;
    localparam int REG_AW   = 2;

    localparam int ARM_CHANNEL = 4;
    localparam logic [15:0] ARM_VALUE  = 16'd2000;
    localparam logic [15:0] PCT_OFFSET = 16'd1000;
    localparam logic [15:0] CHK_INIT   = 16'hFFFF;

    // Input operations.
    localparam logic [OP_W-1:0] OP_BYTE  = 2'd0;
    localparam logic [OP_W-1:0] OP_TICK  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    // Result kinds.
    localparam logic [KIND_W-1:0] KIND_CHAN     = 3'd0;
    localparam logic [KIND_W-1:0] KIND_HDR_REJ  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_CHK_REJ  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_FS_OK    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_FS_TRIP  = 3'd4;

    // Configuration register indexes.
    localparam logic [REG_AW-1:0] REG_LENGTH   = 2'd0;
    localparam logic [REG_AW-1:0] REG_COMMAND  = 2'd1;
    localparam logic [REG_AW-1:0] REG_FS_LIMIT = 2'd2;

    // Frame positions with a special meaning.
    localparam logic [POS_W-1:0] POS_LEN    = 5'd0;
    localparam logic [POS_W-1:0] POS_CMD    = 5'd1;
    localparam logic [POS_W-1:0] POS_FIRST_CH_HI = 5'd3;
    localparam logic [POS_W-1:0] POS_CHK_LO = 5'd30;
    localparam logic [POS_W-1:0] POS_CHK_HI = 5'd31;

    typedef struct packed {
        logic             we;
        logic [CH_AW-1:0] addr;
        logic [15:0]      data;
    } t_ram_wr;

    // Request from the frame control to the result stage, valid on an accepted beat.
    typedef struct packed {
        logic              imm_valid;
        logic [KIND_W-1:0] imm_kind;
        logic              burst_start;
        logic              armed;
    } t_res_req;

    // Status of the result stage seen by the frame control.
    typedef struct packed {
        logic             out_free;
        logic             busy;
        logic             burst;
        logic [CH_AW-1:0] rd_idx;
    } t_emit_stat;

endpackage

// ===== rtl/core/ibfd_chan_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibfd_chan_ram
// Channel value store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ibfd_chan_ram (
    input  logic                        i_clk,
    input  ibfd_pkg::t_ram_wr           i_wr,
    input  logic                        i_rd_en,
    input  logic [ibfd_pkg::CH_AW-1:0]  i_rd_addr,
    output logic [15:0]                 o_rd_data
);

    logic [15:0] r_mem [ibfd_pkg::CHANNELS];
    logic [15:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/core/ibfd_frame_ctl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibfd_frame_ctl
// Byte position tracking, header and checksum checks, channel writes,
// failsafe counter and configuration registers.
// ----------------------------------------------------------------------------
module ibfd_frame_ctl (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [ibfd_pkg::REG_AW-1:0]    i_cfg_addr,
    input  logic [7:0]                     i_cfg_wdata,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [ibfd_pkg::OP_W-1:0]      i_op,
    input  logic [7:0]                     i_byte,
    input  logic                           i_start,
    input  ibfd_pkg::t_emit_stat           i_stat,
    output ibfd_pkg::t_res_req             o_req,
    output ibfd_pkg::t_ram_wr              o_wr
);

    logic [7:0]                    r_len_code;
    logic [7:0]                    r_cmd_code;
    logic [7:0]                    r_fs_limit;
    logic [ibfd_pkg::POS_W-1:0]    r_pos;
    logic [15:0]                   r_chk;
    logic [7:0]                    r_chk_lo;
    logic [7:0]                    r_pend;
    logic                          r_hdr_bad;
    logic                          r_arm4;
    logic [7:0]                    r_fs_cnt;

    logic [ibfd_pkg::POS_W-1:0]    pos;
    logic [ibfd_pkg::IDX_W-1:0]    ch;
    logic [15:0]                   got;
    logic [15:0]                   ch_value;
    logic [7:0]                    n_fs_cnt;
    logic                          is_byte;
    logic                          is_tick;
    logic                          is_wr;
    logic                          blocked_wr;
    logic                          gives_result;
    logic                          acc;

    always_comb begin
        pos      = i_start ? ibfd_pkg::POS_LEN : r_pos;
        is_byte  = (i_op == ibfd_pkg::OP_BYTE);
        is_tick  = (i_op == ibfd_pkg::OP_TICK);
        // Position 2k+3 carries the high byte of channel k.
        ch       = pos[ibfd_pkg::POS_W-1:1] - 4'd1;
        ch_value = {i_byte, r_pend};
        got      = {i_byte, r_chk_lo};
        is_wr    = is_byte && pos[0] && (pos >= ibfd_pkg::POS_FIRST_CH_HI)
                   && (pos < ibfd_pkg::POS_CHK_LO)
                   && ({1'b0, ch} < 5'(ibfd_pkg::CHANNELS));
        // A write of the next frame waits until that entry has been read out.
        blocked_wr   = is_wr && i_stat.burst
                       && (ch >= ibfd_pkg::IDX_W'(i_stat.rd_idx));
        gives_result = is_tick || (is_byte && (pos == ibfd_pkg::POS_CHK_HI));
        o_ready  = gives_result ? (i_stat.out_free && !i_stat.busy) : !blocked_wr;
        acc      = i_valid && o_ready;
        n_fs_cnt = (r_fs_cnt == 8'hFF) ? r_fs_cnt : r_fs_cnt + 8'd1;
    end

    always_comb begin
        o_req.imm_valid   = 1'b0;
        o_req.imm_kind    = ibfd_pkg::KIND_CHAN;
        o_req.burst_start = 1'b0;
        o_req.armed       = r_arm4;
        if (acc && is_tick) begin
            o_req.imm_valid = 1'b1;
            o_req.imm_kind  = (n_fs_cnt <= r_fs_limit) ? ibfd_pkg::KIND_FS_OK
                                                       : ibfd_pkg::KIND_FS_TRIP;
        end else if (acc && is_byte && (pos == ibfd_pkg::POS_CHK_HI)) begin
            if (r_hdr_bad) begin
                o_req.imm_valid = 1'b1;
                o_req.imm_kind  = ibfd_pkg::KIND_HDR_REJ;
            end else if (got != r_chk) begin
                o_req.imm_valid = 1'b1;
                o_req.imm_kind  = ibfd_pkg::KIND_CHK_REJ;
            end else begin
                o_req.burst_start = 1'b1;
            end
        end
    end

    always_comb begin
        o_wr.we   = acc && is_wr;
        o_wr.addr = ch[ibfd_pkg::CH_AW-1:0];
        o_wr.data = ch_value;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len_code <= 8'd32;
            r_cmd_code <= 8'd64;
            r_fs_limit <= 8'd10;
            r_pos      <= '0;
            r_chk      <= ibfd_pkg::CHK_INIT;
            r_chk_lo   <= '0;
            r_pend     <= '0;
            r_hdr_bad  <= 1'b0;
            r_arm4     <= 1'b0;
            r_fs_cnt   <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    ibfd_pkg::REG_LENGTH:   r_len_code <= i_cfg_wdata;
                    ibfd_pkg::REG_COMMAND:  r_cmd_code <= i_cfg_wdata;
                    ibfd_pkg::REG_FS_LIMIT: r_fs_limit <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (acc) begin
                case (i_op)
                    ibfd_pkg::OP_TICK:  r_fs_cnt <= n_fs_cnt;
                    ibfd_pkg::OP_CLEAR: r_fs_cnt <= '0;
                    ibfd_pkg::OP_BYTE: begin
                        r_pos <= pos + 5'd1;
                        if (pos == ibfd_pkg::POS_LEN) begin
                            r_chk     <= ibfd_pkg::CHK_INIT - {8'd0, i_byte};
                            r_hdr_bad <= (i_byte != r_len_code);
                        end else if (pos < ibfd_pkg::POS_CHK_LO) begin
                            r_chk <= r_chk - {8'd0, i_byte};
                            if (pos == ibfd_pkg::POS_CMD) begin
                                if (i_byte != r_cmd_code) begin
                                    r_hdr_bad <= 1'b1;
                                end
                            end else if (!pos[0]) begin
                                r_pend <= i_byte;
                            end
                        end else if (pos == ibfd_pkg::POS_CHK_LO) begin
                            r_chk_lo <= i_byte;
                        end
                        if (is_wr && (ch == ibfd_pkg::IDX_W'(ibfd_pkg::ARM_CHANNEL))) begin
                            r_arm4 <= (ch_value == ibfd_pkg::ARM_VALUE);
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

endmodule

// ===== rtl/core/ibfd_emit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibfd_emit
// Result stage: reads the channel store out in order after a good frame, or loads
// an immediate result, and holds each in the output register until taken.
// ----------------------------------------------------------------------------
module ibfd_emit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  ibfd_pkg::t_res_req             i_req,
    output ibfd_pkg::t_emit_stat           o_stat,
    output logic                           o_rd_en,
    output logic [ibfd_pkg::CH_AW-1:0]     o_rd_addr,
    input  logic [15:0]                    i_rd_data,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [ibfd_pkg::KIND_W-1:0]    o_kind,
    output logic [ibfd_pkg::IDX_W-1:0]     o_idx,
    output logic [15:0]                    o_raw,
    output logic [15:0]                    o_pct,
    output logic                           o_armed,
    output logic                           o_last
);

    logic                          r_burst;
    logic [ibfd_pkg::CH_AW-1:0]    r_rd_idx;
    logic                          r_arm;
    logic                          r_rd_valid;
    logic [ibfd_pkg::CH_AW-1:0]    r_rd_ch;
    logic                          r_out_valid;
    logic [ibfd_pkg::KIND_W-1:0]   r_kind;
    logic [ibfd_pkg::IDX_W-1:0]    r_idx;
    logic [15:0]                   r_raw;
    logic [15:0]                   r_pct;
    logic                          r_armed;
    logic                          r_last;

    logic out_free;
    logic mv_rd;
    logic issue;

    always_comb begin
        out_free = !r_out_valid || i_ready;
        mv_rd    = r_rd_valid && out_free;
        // The read data register is refilled only once its beat moves on.
        issue    = r_burst && (!r_rd_valid || mv_rd);
        o_stat.out_free = out_free;
        o_stat.busy     = r_burst || r_rd_valid;
        o_stat.burst    = r_burst;
        o_stat.rd_idx   = r_rd_idx;
    end

    assign o_rd_en   = issue;
    assign o_rd_addr = r_rd_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_burst     <= 1'b0;
            r_rd_idx    <= '0;
            r_rd_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_req.burst_start) begin
                r_burst  <= 1'b1;
                r_rd_idx <= '0;
            end else if (issue) begin
                if (r_rd_idx == ibfd_pkg::CH_AW'(ibfd_pkg::CHANNELS - 1)) begin
                    r_burst <= 1'b0;
                end else begin
                    r_rd_idx <= r_rd_idx + 1'b1;
                end
            end
            if (issue) begin
                r_rd_valid <= 1'b1;
            end else if (mv_rd) begin
                r_rd_valid <= 1'b0;
            end
            if (mv_rd || i_req.imm_valid) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.burst_start) begin
            r_arm <= i_req.armed;
        end
        if (issue) begin
            r_rd_ch <= r_rd_idx;
        end
        if (mv_rd) begin
            r_kind  <= ibfd_pkg::KIND_CHAN;
            r_idx   <= ibfd_pkg::IDX_W'(r_rd_ch);
            r_raw   <= i_rd_data;
            r_pct   <= i_rd_data - ibfd_pkg::PCT_OFFSET;
            r_armed <= r_arm;
            r_last  <= (r_rd_ch == ibfd_pkg::CH_AW'(ibfd_pkg::CHANNELS - 1));
        end else if (i_req.imm_valid) begin
            r_kind  <= i_req.imm_kind;
            r_idx   <= '0;
            r_raw   <= '0;
            r_pct   <= '0;
            r_armed <= 1'b0;
            r_last  <= 1'b1;
        end
    end

    assign o_valid = r_out_valid;
    assign o_kind  = r_kind;
    assign o_idx   = r_idx;
    assign o_raw   = r_raw;
    assign o_pct   = r_pct;
    assign o_armed = r_armed;
    assign o_last  = r_last;

endmodule

// ===== rtl/core/ibus_frame_decoder_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibus_frame_decoder_unit
// Receiver frame decoder: checks header and checksum of 32-byte frames and
// streams out the channel values of each good frame.
// ----------------------------------------------------------------------------
//  Channel   Dir  Carries
//  s_axis    in   one byte, failsafe tick or failsafe clear per beat
//  m_axis    out  one channel value, rejection or failsafe status per beat
//  cfg       in   write of length code, command code, failsafe limit
//
// One input beat is taken per cycle unless stalled. A good frame ends in CHANNELS
// result beats, one per cycle unless stalled, read in order from the channel
// store through its single read port. Bytes of the next frame keep flowing
// meanwhile; a channel write waits only while its entry has not yet been read
// out. Beats that produce a result wait for a free output register and for the
// readout to finish. Reset is synchronous; the channel store needs no clearing.
// ----------------------------------------------------------------------------
module ibus_frame_decoder_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [ibfd_pkg::REG_AW-1:0]  i_cfg_addr,
    input  logic [7:0]                   i_cfg_wdata,
    input  logic                         i_s_axis_tvalid,
    output logic                         o_s_axis_tready,
    input  logic [7:0]                   i_s_axis_tdata,   // [7:0] rx_byte
    input  logic [2:0]                   i_s_axis_tuser,   // [1:0] op, [2] frame_start
    output logic                         o_m_axis_tvalid,
    input  logic                         i_m_axis_tready,
    // [3:0] channel_index, [19:4] raw_value, [35:20] percent_value, [36] armed
    output logic [39:0]                  o_m_axis_tdata,
    output logic [2:0]                   o_m_axis_tuser,   // [2:0] kind
    output logic                         o_m_axis_tlast
);

    ibfd_pkg::t_emit_stat            stat;
    ibfd_pkg::t_res_req              req;
    ibfd_pkg::t_ram_wr               wr;
    logic                            rd_en;
    logic [ibfd_pkg::CH_AW-1:0]      rd_addr;
    logic [15:0]                     rd_data;
    logic [ibfd_pkg::IDX_W-1:0]      out_idx;
    logic [15:0]                     out_raw;
    logic [15:0]                     out_pct;
    logic                            out_armed;

    ibfd_frame_ctl u_ctl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_op        (i_s_axis_tuser[1:0]),
        .i_byte      (i_s_axis_tdata),
        .i_start     (i_s_axis_tuser[2]),
        .i_stat      (stat),
        .o_req       (req),
        .o_wr        (wr)
    );

    ibfd_chan_ram u_ram (
        .i_clk     (i_clk),
        .i_wr      (wr),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    ibfd_emit u_emit (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (req),
        .o_stat    (stat),
        .o_rd_en   (rd_en),
        .o_rd_addr (rd_addr),
        .i_rd_data (rd_data),
        .o_valid   (o_m_axis_tvalid),
        .i_ready   (i_m_axis_tready),
        .o_kind    (o_m_axis_tuser),
        .o_idx     (out_idx),
        .o_raw     (out_raw),
        .o_pct     (out_pct),
        .o_armed   (out_armed),
        .o_last    (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {3'b000, out_armed, out_pct, out_raw, out_idx};

endmodule
